### sv/spt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the shortest-path tree block.
// No dependencies.
package spt_pkg;

    localparam int unsigned KIND_W = 2;
    localparam int unsigned VID_W  = 6;
    localparam int unsigned WGT_W  = 16;
    localparam int unsigned LINE_W = 5;

    // Operation codes of an input transfer
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    // Stored edge: src, dst, weight, line, direction
    typedef struct packed {
        logic [VID_W-1:0]  src;
        logic [VID_W-1:0]  dst;
        logic [WGT_W-1:0]  cost;
        logic [LINE_W-1:0] line;
        logic              dir;
    } t_edge;

    // Path record of a vertex
    typedef struct packed {
        logic [VID_W-1:0]  pred;
        logic [LINE_W-1:0] line;
        logic              dir;
        logic [WGT_W-1:0]  cost;
    } t_rec;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;     // capture input fields
        logic clr_graph;   // edge count and overflow to zero
        logic add_edge;    // write captured edge
        logic q_init;      // clear flags, start node scan
        logic scan_step;   // examine one vertex in min search
        logic settle;      // settle chosen vertex, start edge walk
        logic edge_rd;     // issue edge read
        logic edge_proc;   // evaluate edge read data
        logic out_rd;      // issue result read
        logic out_load;    // fill output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic start_ok;
        logic scan_done;
        logic found;
        logic edge_done;
        logic out_done;
    } t_sts;

endpackage

### sv/spt_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module spt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### sv/spt_datapath.sv
`timescale 1ns / 1ps
// Datapath: edge store, distance and path memories, scan counters, output register.
// Depends on spt_pkg and spt_ram.
module spt_datapath #(
    parameter int unsigned NODES = 64,
    parameter int unsigned EDGES = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  spt_pkg::t_cmd             i_cmd,
    output spt_pkg::t_sts             o_sts,
    input  logic [spt_pkg::KIND_W-1:0] i_kind,
    input  logic [spt_pkg::VID_W-1:0]  i_from_node,
    input  logic [spt_pkg::VID_W-1:0]  i_to_node,
    input  logic [spt_pkg::WGT_W-1:0]  i_weight,
    input  logic [spt_pkg::LINE_W-1:0] i_line_id,
    input  logic                       i_direction,
    input  logic [spt_pkg::VID_W-1:0]  i_start_node,
    output logic [spt_pkg::VID_W-1:0]  o_node,
    output logic                       o_reached,
    output logic [spt_pkg::VID_W-1:0]  o_pred_node,
    output logic [spt_pkg::LINE_W-1:0] o_pred_line,
    output logic                       o_pred_direction,
    output logic [spt_pkg::WGT_W-1:0]  o_last_edge_weight,
    output logic                       o_edge_overflow,
    output logic                       o_last
);
    localparam int unsigned NA_W  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int unsigned NC_W  = $clog2(NODES + 1);
    localparam int unsigned EA_W  = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam int unsigned EC_W  = $clog2(EDGES + 1);
    // distance grows by at most a weight per settled vertex
    localparam int unsigned DST_W = spt_pkg::WGT_W + NC_W;
    localparam int unsigned EDGE_BITS = $bits(spt_pkg::t_edge);
    localparam int unsigned REC_BITS  = $bits(spt_pkg::t_rec);

    // Captured input transfer
    logic [spt_pkg::KIND_W-1:0] r_kind;
    spt_pkg::t_edge             r_new_edge;
    logic [spt_pkg::VID_W-1:0]  r_start;

    logic [EC_W-1:0] r_edge_count;
    logic            r_overflow;

    // Per-vertex flags in flip-flops (fixed-place reads during scan)
    logic [NODES-1:0] r_settled;
    logic [NODES-1:0] r_reached;

    // Min search
    logic [NC_W-1:0]  r_vidx;
    logic             r_found;
    logic [NA_W-1:0]  r_u;
    logic [DST_W-1:0] r_du;
    // distance read of the previous scan step
    logic             r_scan_vld;
    logic [NA_W-1:0]  r_scan_v;

    // Edge walk
    logic [EC_W-1:0]  r_eidx;

    // Output walk
    logic [NC_W-1:0]  r_oidx;
    logic [NA_W-1:0]  r_oaddr;

    logic           start_ok;
    logic [NA_W-1:0] start_a;
    assign start_ok = {{(32-spt_pkg::VID_W){1'b0}}, r_start} < NODES;
    assign start_a  = NA_W'(r_start);

    // ---- memories ----
    spt_pkg::t_edge  edge_rd;
    logic [EDGE_BITS-1:0] edge_rbits;
    logic [EA_W-1:0] edge_raddr;
    assign edge_raddr = EA_W'(r_eidx);
    assign edge_rd    = spt_pkg::t_edge'(edge_rbits);

    spt_ram #(.WIDTH(EDGE_BITS), .DEPTH(EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_edge && (r_edge_count < EC_W'(EDGES))),
        .i_waddr (EA_W'(r_edge_count)),
        .i_wdata (r_new_edge),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rbits)
    );

    // Distance memory: read port shared by scan and relaxation
    logic             dist_we;
    logic [NA_W-1:0]  dist_waddr;
    logic [DST_W-1:0] dist_wdata;
    logic [NA_W-1:0]  dist_raddr;
    logic [DST_W-1:0] dist_rdata;

    spt_ram #(.WIDTH(DST_W), .DEPTH(NODES)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (dist_raddr),
        .o_rdata (dist_rdata)
    );

    logic            rec_we;
    logic [NA_W-1:0] rec_waddr;
    spt_pkg::t_rec   rec_wdata;
    logic [REC_BITS-1:0] rec_rbits;
    spt_pkg::t_rec   rec_rd;
    assign rec_rd = spt_pkg::t_rec'(rec_rbits);

    spt_ram #(.WIDTH(REC_BITS), .DEPTH(NODES)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (rec_waddr),
        .i_wdata (rec_wdata),
        .i_raddr (NA_W'(r_oidx)),
        .o_rdata (rec_rbits)
    );

    // ---- relaxation of the edge whose data is now registered ----
    // Edge walk has two steps: edge_rd reads the edge, and edge_proc, issued twice,
    // takes the edge data and then the target distance. So we keep the edge in r_cur across them.
    spt_pkg::t_edge   r_cur;
    logic             r_cur_vld;
    logic [NA_W-1:0]  tgt;
    logic             tgt_ok;
    logic             tgt_known;
    logic [DST_W-1:0] nd;
    logic             relax;

    assign tgt       = NA_W'(r_cur.dst);
    assign tgt_ok    = {{(32-spt_pkg::VID_W){1'b0}}, r_cur.dst} < NODES;
    assign tgt_known = r_reached[tgt] || (tgt == start_a);
    assign nd        = r_du + DST_W'(r_cur.cost);
    assign relax     = r_cur_vld && i_cmd.edge_proc && (r_cur.src == spt_pkg::VID_W'(r_u))
                       && tgt_ok && (!tgt_known || (dist_rdata > nd));

    // read address select: scan reads vertex r_vidx; edge walk reads target
    always_comb begin
        if (i_cmd.edge_proc || i_cmd.edge_rd) begin
            dist_raddr = NA_W'(edge_rd.dst);
        end else begin
            dist_raddr = NA_W'(r_vidx);
        end
    end

    // write: query start writes zero at source, relax writes nd
    always_comb begin
        dist_we    = relax || (i_cmd.q_init && start_ok);
        dist_waddr = relax ? tgt : start_a;
        dist_wdata = relax ? nd : '0;
        rec_we     = relax;
        rec_waddr  = tgt;
        rec_wdata  = '{pred: spt_pkg::VID_W'(r_u), line: r_cur.line,
                       dir: r_cur.dir, cost: r_cur.cost};
    end

    // scan candidate from previous step
    logic scan_known;
    logic take;
    assign scan_known = r_reached[r_scan_v] || (r_scan_v == start_a);
    assign take = r_scan_vld && scan_known && !r_settled[r_scan_v]
                  && (!r_found || (dist_rdata < r_du));

    logic scan_last;
    assign scan_last = (r_vidx == NC_W'(NODES));

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= '0;
            r_overflow   <= 1'b0;
            r_settled    <= '0;
            r_reached    <= '0;
            r_found      <= 1'b0;
            r_scan_vld   <= 1'b0;
            r_cur_vld    <= 1'b0;
            r_vidx       <= '0;
            r_eidx       <= '0;
            r_oidx       <= '0;
        end else begin
            if (i_cmd.clr_graph) begin
                r_edge_count <= '0;
                r_overflow   <= 1'b0;
            end
            if (i_cmd.add_edge) begin
                if (r_edge_count < EC_W'(EDGES)) begin
                    r_edge_count <= r_edge_count + 1'b1;
                end else begin
                    r_overflow <= 1'b1;
                end
            end
            // query start
            if (i_cmd.q_init) begin
                r_settled  <= '0;
                r_reached  <= '0;
                r_vidx     <= '0;
                r_found    <= 1'b0;
                r_scan_vld <= 1'b0;
                r_oidx     <= '0;
            end
            // min search: one vertex per cycle, compared in the cycle after its read
            if (i_cmd.scan_step) begin
                r_scan_vld <= !scan_last;
                r_scan_v   <= NA_W'(r_vidx);
                if (!scan_last) begin
                    r_vidx <= r_vidx + 1'b1;
                end
                if (take) begin
                    r_found <= 1'b1;
                    r_u     <= r_scan_v;
                    r_du    <= dist_rdata;
                end
            end
            // settle, start edge walk and rearm the search for the next round
            if (i_cmd.settle) begin
                r_settled[r_u] <= 1'b1;
                r_eidx         <= '0;
                r_cur_vld      <= 1'b0;
                r_vidx         <= '0;
                r_found        <= 1'b0;
                r_scan_vld     <= 1'b0;
            end
            if (i_cmd.edge_rd) begin
                r_eidx    <= r_eidx + 1'b1;
                r_cur_vld <= 1'b0;
            end
            if (i_cmd.edge_proc) begin
                r_cur     <= edge_rd;
                r_cur_vld <= !r_cur_vld;
                if (relax) begin
                    r_reached[tgt] <= 1'b1;
                end
            end
            if (i_cmd.out_rd) begin
                r_oaddr <= NA_W'(r_oidx);
                r_oidx  <= r_oidx + 1'b1;
            end
        end
    end

    // input capture and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind     <= i_kind;
            r_new_edge <= '{src: i_from_node, dst: i_to_node, cost: i_weight,
                            line: i_line_id, dir: i_direction};
            r_start    <= i_start_node;
        end
        if (i_cmd.out_load) begin
            o_node             <= spt_pkg::VID_W'(r_oaddr);
            o_reached          <= r_reached[r_oaddr];
            o_pred_node        <= r_reached[r_oaddr] ? rec_rd.pred : '0;
            o_pred_line        <= r_reached[r_oaddr] ? rec_rd.line : '0;
            o_pred_direction   <= r_reached[r_oaddr] && rec_rd.dir;
            o_last_edge_weight <= r_reached[r_oaddr] ? rec_rd.cost : '0;
            o_edge_overflow    <= r_overflow;
            o_last             <= (r_oaddr == NA_W'(NODES - 1));
        end
    end

    assign o_sts = '{kind: r_kind, start_ok: start_ok, scan_done: scan_last,
                     found: r_found || take,
                     edge_done: (r_eidx == r_edge_count),
                     out_done: (r_oidx == NC_W'(NODES))};
endmodule

### sv/spt_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences graph loads, the Dijkstra rounds and the
// result stream. Depends on spt_pkg.
module spt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  spt_pkg::t_sts i_sts,
    output spt_pkg::t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_INIT, S_SCAN, S_SETTLE, S_ERD, S_EPROC1, S_EPROC2,
        S_ORD, S_OLOAD, S_OSEND
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority case (i_sts.kind)
                    spt_pkg::KIND_CLEAR: begin
                        o_cmd.clr_graph = 1'b1;
                        n_state = S_IDLE;
                    end
                    spt_pkg::KIND_ADD: begin
                        o_cmd.add_edge = 1'b1;
                        n_state = S_IDLE;
                    end
                    spt_pkg::KIND_QUERY: begin
                        o_cmd.q_init = 1'b1;
                        n_state = i_sts.start_ok ? S_SCAN : S_ORD;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = i_sts.found ? S_SETTLE : S_ORD;
                end
            end
            S_SETTLE: begin
                o_cmd.settle = 1'b1;
                n_state = S_ERD;
            end
            S_ERD: begin
                if (i_sts.edge_done) begin
                    // restart search for next round
                    o_cmd.q_init = 1'b0;
                    n_state = S_INIT;
                end else begin
                    o_cmd.edge_rd = 1'b1;
                    n_state = S_EPROC1;
                end
            end
            S_EPROC1: begin
                // edge data arrives, target distance read issued
                o_cmd.edge_proc = 1'b1;
                n_state = S_EPROC2;
            end
            S_EPROC2: begin
                // target distance arrives, relax
                o_cmd.edge_proc = 1'b1;
                n_state = S_ERD;
            end
            S_INIT: begin
                o_cmd.edge_proc = 1'b0;
                n_state = S_SCAN;
            end
            S_ORD: begin
                if (i_sts.out_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.out_rd = 1'b1;
                    n_state = S_OLOAD;
                end
            end
            S_OLOAD: begin
                o_cmd.out_load = 1'b1;
                n_valid = 1'b1;
                n_state = S_OSEND;
            end
            S_OSEND: begin
                if (i_ready) begin
                    n_valid = 1'b0;
                    n_state = S_ORD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end
endmodule

### sv/shortest_path_tree.sv
`timescale 1ns / 1ps
// Top level of the shortest-path tree block: controller plus datapath.
// Depends on spt_pkg, spt_ctrl, spt_datapath.
//
// Usage: one input channel (valid/ready) carries commands: clear graph, add
// edge, run query. Add and clear return nothing. A query clears the
// per-vertex flags, then runs up to NODES rounds; each round scans all
// vertices one per cycle and walks the whole edge store, one stored edge at
// a time. Query time is set by the single read port of the distance memory
// and the sequential minimum search. The query then streams NODES results on
// the output channel, vertex 0 first, with last on vertex NODES-1.
// The input is not accepted while a command is in progress. A stall on the
// output holds the result register and the whole block until it is taken.
// Reset (synchronous, active low) empties the graph and clears the overflow
// flag; no memory clearing pass is needed.
module shortest_path_tree #(
    parameter int unsigned NODES = 64,
    parameter int unsigned EDGES = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [spt_pkg::KIND_W-1:0] i_kind,
    input  logic [spt_pkg::VID_W-1:0]  i_from_node,
    input  logic [spt_pkg::VID_W-1:0]  i_to_node,
    input  logic [spt_pkg::WGT_W-1:0]  i_weight,
    input  logic [spt_pkg::LINE_W-1:0] i_line_id,
    input  logic                       i_direction,
    input  logic [spt_pkg::VID_W-1:0]  i_start_node,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [spt_pkg::VID_W-1:0]  o_node,
    output logic                       o_reached,
    output logic [spt_pkg::VID_W-1:0]  o_pred_node,
    output logic [spt_pkg::LINE_W-1:0] o_pred_line,
    output logic                       o_pred_direction,
    output logic [spt_pkg::WGT_W-1:0]  o_last_edge_weight,
    output logic                       o_edge_overflow,
    output logic                       o_last
);
    spt_pkg::t_cmd cmd;
    spt_pkg::t_sts sts;

    spt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    spt_datapath #(.NODES(NODES), .EDGES(EDGES)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_kind             (i_kind),
        .i_from_node        (i_from_node),
        .i_to_node          (i_to_node),
        .i_weight           (i_weight),
        .i_line_id          (i_line_id),
        .i_direction        (i_direction),
        .i_start_node       (i_start_node),
        .o_node             (o_node),
        .o_reached          (o_reached),
        .o_pred_node        (o_pred_node),
        .o_pred_line        (o_pred_line),
        .o_pred_direction   (o_pred_direction),
        .o_last_edge_weight (o_last_edge_weight),
        .o_edge_overflow    (o_edge_overflow),
        .o_last             (o_last)
    );
endmodule
